// ===== sv/spsil_pkg.sv =====
// ----------------------------------------------------------------------------
// spsil_pkg
// Types, codes and sizes shared by the sorted insertion list core.
// ----------------------------------------------------------------------------
`default_nettype none

package spsil_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = 6;
   localparam int POS_W    = 5;
   localparam int ID_COUNT = 256;
   localparam int FLAG_W   = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DUP  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef struct packed {
      logic               command;
      logic [7:0]         item_id;
      logic signed [31:0] priority_req;
      logic [31:0]        payload;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         status;
      logic [4:0]         position;
      logic [7:0]         out_id;
      logic signed [31:0] out_priority;
      logic [31:0]        out_payload;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic load;
      logic insert;
      logic drain_step;
      logic drain_empty;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_drain;
      logic list_empty;
      logic list_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/spsil_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsil_ctrl
// Sequencer: takes a command word, then steps the datapath through one
// insert or through a drain of the whole list.
// ----------------------------------------------------------------------------
`default_nettype none

module spsil_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire spsil_pkg::dp_status_type status,
   output spsil_pkg::ctrl_cmd_type     cmd
);

   spsil_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spsil_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spsil_pkg::ST_IDLE: begin
            if (start) begin
               state_in = status.is_drain ? spsil_pkg::ST_DRAIN : spsil_pkg::ST_INSERT;
            end
         end
         spsil_pkg::ST_INSERT: begin
            state_in = spsil_pkg::ST_IDLE;
         end
         spsil_pkg::ST_DRAIN: begin
            if (status.list_empty || status.list_last) begin
               state_in = spsil_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spsil_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b1;
      cmd  = '0;
      unique case (state_ff)
         spsil_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         spsil_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
         end
         spsil_pkg::ST_DRAIN: begin
            cmd.drain_empty = status.list_empty;
            cmd.drain_step  = !status.list_empty;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/spsil_dp.sv =====
// ----------------------------------------------------------------------------
// spsil_dp
// Datapath: sorted entry array with parallel compare and shift, membership
// flags and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module spsil_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spsil_pkg::req_type     req_data,
   input  wire spsil_pkg::ctrl_cmd_type cmd,
   output spsil_pkg::dp_status_type    status,
   output logic                        rsp_valid,
   output spsil_pkg::rsp_type          rsp_data
);

   logic [7:0]         id_ff   [spsil_pkg::CAPACITY];
   logic [7:0]         id_in   [spsil_pkg::CAPACITY];
   logic signed [31:0] prio_ff [spsil_pkg::CAPACITY];
   logic signed [31:0] prio_in [spsil_pkg::CAPACITY];
   logic [31:0]        data_ff [spsil_pkg::CAPACITY];
   logic [31:0]        data_in [spsil_pkg::CAPACITY];

   logic [spsil_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [spsil_pkg::ID_COUNT-1:0] flags_ff, flags_in;
   logic [spsil_pkg::POS_W-1:0]    rank_ff, rank_in;
   spsil_pkg::req_type             req_ff, req_in;
   logic [spsil_pkg::CAPACITY-1:0] lt_ff, lt_in;
   logic                           dup_ff, dup_in;
   logic                           full_ff, full_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   spsil_pkg::rsp_type             rsp_ff, rsp_in;

   logic [spsil_pkg::CAPACITY-1:0] mark;
   logic [spsil_pkg::CAPACITY-1:0] mark_prev;
   logic [spsil_pkg::POS_W-1:0]    pos;
   logic [spsil_pkg::FLAG_W-1:0]   flag_idx;
   logic [spsil_pkg::FLAG_W-1:0]   req_flag_idx;
   logic                           insert_ok;

   assign flag_idx     = req_data.item_id[spsil_pkg::FLAG_W-1:0];
   assign req_flag_idx = req_ff.item_id[spsil_pkg::FLAG_W-1:0];
   assign insert_ok    = cmd.insert && !dup_ff && !full_ff;

   assign status.is_drain   = (req_data.command == spsil_pkg::CMD_DRAIN);
   assign status.list_empty = (count_ff == '0);
   assign status.list_last  = (count_ff == spsil_pkg::CNT_W'(1));

   // compare the new key against every live slot at acceptance
   always_comb begin
      for (int i = 0; i < spsil_pkg::CAPACITY; i++) begin
         lt_in[i] = lt_ff[i];
      end
      req_in  = req_ff;
      dup_in  = dup_ff;
      full_in = full_ff;
      if (cmd.load) begin
         req_in  = req_data;
         dup_in  = flags_ff[flag_idx];
         full_in = (count_ff >= spsil_pkg::CNT_W'(spsil_pkg::CAPACITY));
         for (int i = 0; i < spsil_pkg::CAPACITY; i++) begin
            lt_in[i] = (spsil_pkg::CNT_W'(i) < count_ff) &&
                       (req_data.priority_req < prio_ff[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < spsil_pkg::CAPACITY; i++) begin
         mark[i] = lt_ff[i] || (spsil_pkg::CNT_W'(i) == count_ff);
      end
      mark_prev = {mark[spsil_pkg::CAPACITY-2:0], 1'b0};
      pos = '0;
      for (int i = spsil_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (mark[i]) begin
            pos = spsil_pkg::POS_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < spsil_pkg::CAPACITY; i++) begin
         id_in[i]   = id_ff[i];
         prio_in[i] = prio_ff[i];
         data_in[i] = data_ff[i];
      end
      count_in     = count_ff;
      flags_in     = flags_ff;
      rank_in      = rank_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         rank_in = '0;
      end

      if (cmd.insert) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.kind         = spsil_pkg::KIND_INSERT;
         rsp_in.out_id       = req_ff.item_id;
         rsp_in.last         = 1'b1;
         if (dup_ff) begin
            rsp_in.status = spsil_pkg::STAT_DUP;
         end else if (full_ff) begin
            rsp_in.status = spsil_pkg::STAT_FULL;
         end else begin
            rsp_in.status   = spsil_pkg::STAT_OK;
            rsp_in.position = pos;
         end
      end

      // open a gap at the insertion slot and shift the tail up
      if (insert_ok) begin
         for (int i = 1; i < spsil_pkg::CAPACITY; i++) begin
            if (mark_prev[i]) begin
               id_in[i]   = id_ff[i-1];
               prio_in[i] = prio_ff[i-1];
               data_in[i] = data_ff[i-1];
            end
         end
         for (int i = 0; i < spsil_pkg::CAPACITY; i++) begin
            if (mark[i] && !mark_prev[i]) begin
               id_in[i]   = req_ff.item_id;
               prio_in[i] = req_ff.priority_req;
               data_in[i] = req_ff.payload;
            end
         end
         count_in               = count_ff + spsil_pkg::CNT_W'(1);
         flags_in[req_flag_idx] = 1'b1;
      end

      // emit the head and advance the list down by one slot
      if (cmd.drain_step) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.kind         = spsil_pkg::KIND_ENTRY;
         rsp_in.position     = rank_ff;
         rsp_in.out_id       = id_ff[0];
         rsp_in.out_priority = prio_ff[0];
         rsp_in.out_payload  = data_ff[0];
         rsp_in.last         = status.list_last;
         for (int i = 0; i < spsil_pkg::CAPACITY - 1; i++) begin
            id_in[i]   = id_ff[i+1];
            prio_in[i] = prio_ff[i+1];
            data_in[i] = data_ff[i+1];
         end
         count_in = count_ff - spsil_pkg::CNT_W'(1);
         rank_in  = rank_ff + spsil_pkg::POS_W'(1);
         if (status.list_last) begin
            flags_in = '0;
         end
      end

      if (cmd.drain_empty) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.kind  = spsil_pkg::KIND_EMPTY;
         rsp_in.last  = 1'b1;
         flags_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < spsil_pkg::CAPACITY; i++) begin
         id_ff[i]   <= id_in[i];
         prio_ff[i] <= prio_in[i];
         data_ff[i] <= data_in[i];
      end
      rank_ff <= rank_in;
      req_ff  <= req_in;
      lt_ff   <= lt_in;
      dup_ff  <= dup_in;
      full_ff <= full_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= spsil_pkg::CNT_W'(spsil_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      insert_ok |=> count_ff == $past(count_ff) + spsil_pkg::CNT_W'(1))
      else $error("accepted insert did not grow the list");

   a_drain_clears : assert property (@(posedge clock) disable iff (reset)
      (cmd.drain_step && status.list_last) || cmd.drain_empty
      |=> count_ff == '0 && flags_ff == '0)
      else $error("drain left entries or flags behind");

   a_result_after_cmd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.insert || cmd.drain_step || cmd.drain_empty))
      else $error("result word without a command");

endmodule

`default_nettype wire

// ===== sv/stable_priority_sorted_insert_list_core.sv =====
// ----------------------------------------------------------------------------
// stable_priority_sorted_insert_list_core
// Bounded list of up to 32 entries kept in ascending signed priority order,
// with stable placement of equal keys.
//
// Usage:
//   A request word on req_data is taken when start is high and busy is low.
//   Insert (command 0): the key is compared with all live slots in the
//   accepting cycle; the next cycle shifts the tail up and writes the entry.
//   One status word follows, registered from the write step; it appears as
//   the core goes idle again and can accept the next request.
//   Duplicate id wins over a full list when both apply.
//   Drain (command 1): the head slot is emitted and the list shifted down
//   once per cycle, with busy high until the final step; an empty list
//   gives a single empty marker. Each word is registered and appears in the
//   cycle after its step; last marks the final word.
//   The list and all membership flags are cleared at the end of a drain.
//   Results appear on rsp_data for one cycle each, marked by rsp_valid; the
//   receiver cannot hold them off.
//   Reset empties the list and clears the membership flags at once; the
//   entry slots themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_sorted_insert_list_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire spsil_pkg::req_type req_data,
   output logic                    rsp_valid,
   output spsil_pkg::rsp_type      rsp_data
);

   spsil_pkg::ctrl_cmd_type  cmd;
   spsil_pkg::dp_status_type status;

   spsil_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   spsil_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
